### src/assert_macros.svh
// Assertion macros used by the gesture classifier result queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define BGC_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("bgc assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define BGC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bgc assertion failed");

`endif

### src/bgc_pkg.sv
// Types and constants of the button gesture classifier.
package bgc_pkg;

    localparam int TIMER_BITS_DEFAULT = 16;

    localparam int DEB_W = 10;
    localparam int WIN_W = 16;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET     = 10'd50;
    localparam logic [WIN_W-1:0] DOUBLE_CLICK_RESET = 16'd400;
    localparam logic [WIN_W-1:0] LONG_PRESS_RESET   = 16'd1000;
    localparam logic             PRESSED_RESET      = 1'b1;

    // Result queue: up to two pushes per tick, power-of-two depth.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        GEST_SINGLE   = 2'd0,
        GEST_DOUBLE   = 2'd1,
        GEST_HOLD     = 2'd2,
        GEST_REL_HOLD = 2'd3
    } gesture_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE     = 2'd0,
        CFG_DOUBLE_CLICK = 2'd1,
        CFG_LONG_PRESS   = 2'd2,
        CFG_PRESSED      = 2'd3
    } cfg_index_t;

    typedef struct packed {
        gesture_t gesture;
        logic     last_of_tick;
    } result_t;

    // Results of one tick, slot 0 first.
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        result_t res0;
        result_t res1;
    } push_t;

endpackage

### src/bgc_front.sv
// Front end: debounce, gesture state and classification of each tick.
module bgc_front #(
    parameter int TIMER_BITS = bgc_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept,
    input  logic                         pin_level,
    input  logic                         cfg_we,
    input  bgc_pkg::cfg_index_t          cfg_index,
    input  logic [bgc_pkg::CFG_W-1:0]    cfg_wdata,
    output bgc_pkg::push_t               push
);
    import bgc_pkg::*;

    localparam int CMP_W = (TIMER_BITS > WIN_W) ? TIMER_BITS : WIN_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    logic [DEB_W-1:0]      debounce_cfg_reg;
    logic [WIN_W-1:0]      double_cfg_reg;
    logic [WIN_W-1:0]      long_cfg_reg;
    logic                  pressed_cfg_reg;

    logic                  prev_raw_reg, prev_raw_next;
    logic [DEB_W-1:0]      deb_timer_reg, deb_timer_next;
    logic                  down_reg, down_next;
    logic                  hold_seen_reg, hold_seen_next;
    logic                  awaiting_reg, awaiting_next;
    logic [1:0]            clicks_reg, clicks_next;
    logic [TIMER_BITS-1:0] press_timer_reg, press_timer_next;
    logic [TIMER_BITS-1:0] gap_timer_reg, gap_timer_next;

    logic                  edge_seen;
    logic                  sampled;
    logic                  pressed;
    logic                  single_to;
    logic                  hold_to;
    logic                  rel_valid;
    gesture_t              rel_gesture;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_cfg_reg <= DEBOUNCE_RESET;
            double_cfg_reg   <= DOUBLE_CLICK_RESET;
            long_cfg_reg     <= LONG_PRESS_RESET;
            pressed_cfg_reg  <= PRESSED_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DEBOUNCE:     debounce_cfg_reg <= cfg_wdata[DEB_W-1:0];
                CFG_DOUBLE_CLICK: double_cfg_reg   <= cfg_wdata[WIN_W-1:0];
                CFG_LONG_PRESS:   long_cfg_reg     <= cfg_wdata[WIN_W-1:0];
                CFG_PRESSED:      pressed_cfg_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prev_raw_next    = pin_level;
        deb_timer_next   = deb_timer_reg;
        down_next        = down_reg;
        hold_seen_next   = hold_seen_reg;
        awaiting_next    = awaiting_reg;
        clicks_next      = clicks_reg;
        single_to        = 1'b0;
        hold_to          = 1'b0;
        rel_valid        = 1'b0;
        rel_gesture      = GEST_SINGLE;
        sampled          = 1'b0;
        edge_seen        = (pin_level != prev_raw_reg);
        pressed          = (pin_level == pressed_cfg_reg);

        // saturating tick counters run first
        press_timer_next = press_timer_reg;
        if (down_reg && press_timer_reg != TIMER_MAX) begin
            press_timer_next = press_timer_reg + 1'b1;
        end
        gap_timer_next = gap_timer_reg;
        if (awaiting_reg && gap_timer_reg != TIMER_MAX) begin
            gap_timer_next = gap_timer_reg + 1'b1;
        end

        if (deb_timer_reg != '0) begin
            deb_timer_next = deb_timer_reg - 1'b1;
            sampled        = (deb_timer_reg == DEB_W'(1));
        end else if (edge_seen) begin
            deb_timer_next = (debounce_cfg_reg == '0) ? DEB_W'(1) : debounce_cfg_reg;
        end

        if (sampled) begin
            if (pressed && !down_reg) begin
                down_next        = 1'b1;
                press_timer_next = '0;
                hold_seen_next   = 1'b0;
            end else if (!pressed && down_reg) begin
                down_next = 1'b0;
                if (hold_seen_reg) begin
                    rel_valid     = 1'b1;
                    rel_gesture   = GEST_REL_HOLD;
                    awaiting_next = 1'b0;
                    clicks_next   = 2'd0;
                end else if (CMP_W'(press_timer_next) >= CMP_W'(long_cfg_reg)) begin
                    rel_valid     = 1'b1;
                    rel_gesture   = GEST_SINGLE;
                    awaiting_next = 1'b0;
                    clicks_next   = 2'd0;
                end else if (clicks_reg == 2'd0) begin
                    clicks_next    = 2'd1;
                    awaiting_next  = 1'b1;
                    gap_timer_next = '0;
                end else begin
                    rel_valid     = 1'b1;
                    rel_gesture   = GEST_DOUBLE;
                    awaiting_next = 1'b0;
                    clicks_next   = 2'd0;
                end
            end
        end else begin
            single_to = awaiting_reg && (CMP_W'(gap_timer_next) >= CMP_W'(double_cfg_reg));
            hold_to   = down_reg && !hold_seen_reg &&
                        (CMP_W'(press_timer_next) >= CMP_W'(long_cfg_reg));
            if (single_to || hold_to) begin
                awaiting_next = 1'b0;
                clicks_next   = 2'd0;
            end
            if (hold_to) begin
                hold_seen_next = 1'b1;
            end
        end
    end

    // Pack results into slots; the last filled slot carries the tick marker.
    always_comb begin
        push.valid0            = accept && (rel_valid || single_to || hold_to);
        push.valid1            = accept && single_to && hold_to;
        push.res0.gesture      = rel_valid ? rel_gesture :
                                 (single_to ? GEST_SINGLE : GEST_HOLD);
        push.res0.last_of_tick = !(single_to && hold_to);
        push.res1.gesture      = GEST_HOLD;
        push.res1.last_of_tick = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_raw_reg    <= 1'b0;
            deb_timer_reg   <= '0;
            down_reg        <= 1'b0;
            hold_seen_reg   <= 1'b0;
            awaiting_reg    <= 1'b0;
            clicks_reg      <= 2'd0;
            press_timer_reg <= '0;
            gap_timer_reg   <= '0;
        end else if (accept) begin
            prev_raw_reg    <= prev_raw_next;
            deb_timer_reg   <= deb_timer_next;
            down_reg        <= down_next;
            hold_seen_reg   <= hold_seen_next;
            awaiting_reg    <= awaiting_next;
            clicks_reg      <= clicks_next;
            press_timer_reg <= press_timer_next;
            gap_timer_reg   <= gap_timer_next;
        end
    end

endmodule

### src/bgc_queue.sv
// Result queue between the classifier and the output channel.
`include "assert_macros.svh"

module bgc_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  bgc_pkg::push_t    push,
    output logic              room,
    output logic              m_valid,
    input  logic              m_ready,
    output bgc_pkg::result_t  head
);
    import bgc_pkg::*;

    result_t           entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [1:0]        num_push;
    logic              pop;

    assign num_push = {1'b0, push.valid0} + {1'b0, push.valid1};
    assign pop      = m_valid && m_ready;
    assign m_valid  = (count_reg != '0);
    assign head     = entries_reg[rd_ptr_reg];
    // room for a full tick's worth of results
    assign room     = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + QPTR_W'(num_push);
    assign rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
    assign count_next  = count_reg + QCNT_W'(num_push) - QCNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push.valid0) begin
            entries_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.valid1) begin
            entries_reg[wr_ptr_reg + QPTR_W'(1)] <= push.res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `BGC_ASSERT(a_count_bound, aclk, aresetn, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `BGC_ASSERT(a_slot_order, aclk, aresetn, !push.valid1 || push.valid0)
    `BGC_ASSERT_NEXT(a_no_overflow, aclk, aresetn, push.valid1 && !pop,
                     count_reg == $past(count_reg) + QCNT_W'(2))

endmodule

### src/button_gesture_classifier.sv
// Top level of the button gesture classifier.
//
// Each input transfer is one millisecond tick carrying the raw pin level.
// A change of level starts a debounce wait of debounce_ticks ticks (zero acts
// as one); the level at its end is taken as a press or a release, and edges
// inside the wait are ignored. Debounced events become gestures: single click,
// double click (two short clicks within double_click_ticks), hold (pressed for
// long_press_ticks) and release after hold. A tick gives zero, one or two
// result transfers; last_of_tick marks the final one of its tick. Press and
// gap timers are TIMER_BITS wide and saturate. The front end classifies a tick
// in the cycle it is taken and writes its results into a four-entry queue;
// the queue head drives the result channel from registers. A tick is taken
// every cycle as long as the queue has room for two results, so the sustained
// rate is one tick per cycle while results drain. Configuration writes land
// at once through cfg_we/cfg_index/cfg_wdata and are meant for idle periods.
module button_gesture_classifier #(
    parameter int TIMER_BITS = bgc_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // tick input
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_pin_level,
    // gesture results
    output logic                       m_valid,
    input  logic                       m_ready,
    output bgc_pkg::gesture_t          m_gesture,
    output logic                       m_last_of_tick,
    // configuration writes
    input  logic                       cfg_we,
    input  bgc_pkg::cfg_index_t        cfg_index,
    input  logic [bgc_pkg::CFG_W-1:0]  cfg_wdata
);
    import bgc_pkg::*;

    push_t   push;
    result_t head;
    logic    room;
    logic    accept;

    // Ready only depends on queue space, never on the output side directly.
    assign s_ready = room;
    assign accept  = s_valid && room;

    bgc_front #(
        .TIMER_BITS(TIMER_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .pin_level (s_pin_level),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .push      (push)
    );

    bgc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_gesture      = head.gesture;
    assign m_last_of_tick = head.last_of_tick;

endmodule
